### hdl/ods_pkg.sv
// Shared constants for the ODS stereo ray generator: register indexes, eye
// modes, fixed-point widths and the CORDIC arctangent table.
// No dependencies.
package ods_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_EYE_MODE       = 3'd2;
    localparam logic [2:0] REG_EYE_SEPARATION = 3'd3;
    localparam logic [2:0] REG_POS_X          = 3'd4;
    localparam logic [2:0] REG_POS_Y          = 3'd5;
    localparam logic [2:0] REG_POS_Z          = 3'd6;

    // eye modes
    localparam logic [1:0] EYE_TOP_BOTTOM = 2'd0;
    localparam logic [1:0] EYE_LEFT       = 2'd1;
    localparam logic [1:0] EYE_RIGHT      = 2'd2;

    // defaults for the top-level parameters
    localparam int MAX_IMAGE_DIM_DEF = 4096;
    localparam int CORDIC_STEPS_DEF  = 16;

    // field widths
    localparam int PIX_W  = 20;
    localparam int DIM_W  = 13;
    localparam int IPD_W  = 23;
    localparam int POS_W  = 32;
    localparam int DIR_W  = 16;
    localparam int CFG_W  = 32;

    // both angle dividers run over a 51-bit dividend: column << 24, row << 31
    localparam int DIV_STAGES = 51;
    localparam int ATAN_LEN   = 24;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    // arctangent of 2^-i in 2^-32 turns
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/ods_stereo_ray_generator_unit.sv
// Top level of the ODS stereo ray generator: pixel in, equirectangular ray out.
// Depends on ods_pkg.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ------------------------
//  request   i_pixel_col, i_pixel_row                 i_start high, o_busy low
//  result    o_origin_x/y/z, o_dir_x/y/z              o_valid, one cycle
//  config    i_cfg_idx, i_cfg_wdata                   i_cfg_we, no wait
//
// One request per cycle enters while o_busy is low. The depth of the pipe
// is set by the two bit-per-stage restoring dividers (51 stages) and the
// CORDIC (one stage per step). Reset is synchronous, active low; o_busy
// stays high through reset until r_run is set after it. The result side
// cannot stall, so the pipeline never holds.
module ods_stereo_ray_generator_unit #(
    parameter int MAX_IMAGE_DIM = ods_pkg::MAX_IMAGE_DIM_DEF,
    parameter int CORDIC_STEPS  = ods_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [ods_pkg::PIX_W-1:0]         i_pixel_col,
    input  logic [ods_pkg::PIX_W-1:0]         i_pixel_row,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_idx,
    input  logic [ods_pkg::CFG_W-1:0]         i_cfg_wdata,
    output logic                              o_valid,
    output logic signed [ods_pkg::POS_W-1:0]  o_origin_x,
    output logic signed [ods_pkg::POS_W-1:0]  o_origin_y,
    output logic signed [ods_pkg::POS_W-1:0]  o_origin_z,
    output logic signed [ods_pkg::DIR_W-1:0]  o_dir_x,
    output logic signed [ods_pkg::DIR_W-1:0]  o_dir_y,
    output logic signed [ods_pkg::DIR_W-1:0]  o_dir_z
);
    import ods_pkg::*;

    localparam int DS       = DIV_STAGES;
    localparam int NC       = CORDIC_STEPS;
    localparam int LATENCY  = NC + 56;
    localparam int MAX_CLIP = (MAX_IMAGE_DIM > 8191) ? 8191 : MAX_IMAGE_DIM;
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_CLIP);

    // configuration registers
    logic [DIM_W-1:0]        r_image_width;
    logic [DIM_W-1:0]        r_image_height;
    logic [1:0]              r_eye_mode;
    logic [IPD_W-1:0]        r_eye_separation;
    logic [POS_W-1:0]        r_pos_x;
    logic [POS_W-1:0]        r_pos_y;
    logic [POS_W-1:0]        r_pos_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= DIM_W'(1024);
            r_image_height   <= DIM_W'(512);
            r_eye_mode       <= EYE_TOP_BOTTOM;
            r_eye_separation <= IPD_W'(4194);
            r_pos_x          <= '0;
            r_pos_y          <= '0;
            r_pos_z          <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:    r_image_width    <= i_cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT:   r_image_height   <= i_cfg_wdata[DIM_W-1:0];
                REG_EYE_MODE:       r_eye_mode       <= i_cfg_wdata[1:0];
                REG_EYE_SEPARATION: r_eye_separation <= i_cfg_wdata[IPD_W-1:0];
                REG_POS_X:          r_pos_x          <= i_cfg_wdata;
                REG_POS_Y:          r_pos_y          <= i_cfg_wdata;
                REG_POS_Z:          r_pos_z          <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective dimensions. The user must change config only while the pipe
    // is empty; the block does not enforce it. Every stage reads these directly.
    logic [DIM_W-1:0] w_width;
    logic [DIM_W-1:0] w_height;
    logic             w_tb;
    logic [20:0]      w_hq;        // row divisor in 1/256 pixel

    always_comb begin
        w_width  = (r_image_width == '0) ? DIM_W'(1) :
                   ((r_image_width > DIM_MAX) ? DIM_MAX : r_image_width);
        w_height = (r_image_height == '0) ? DIM_W'(1) :
                   ((r_image_height > DIM_MAX) ? DIM_MAX : r_image_height);
        w_tb     = (r_eye_mode != EYE_LEFT) && (r_eye_mode != EYE_RIGHT);
        w_hq     = w_tb ? {1'b0, w_height, 7'd0} : {w_height, 8'd0};
    end

    // request acceptance
    logic r_run;
    logic w_acc;
    assign o_busy = ~r_run;
    assign w_acc  = i_start & ~o_busy;

    // input stage: wrap the row and pick the eye
    logic            w_left;
    logic [PIX_W-1:0] w_rowp;
    always_comb begin
        priority if (r_eye_mode == EYE_LEFT)  w_left = 1'b1;
        else if (r_eye_mode == EYE_RIGHT)     w_left = 1'b0;
        else                                  w_left = ({1'b0, i_pixel_row} < w_hq);
        w_rowp = ({1'b0, i_pixel_row} > w_hq) ? PIX_W'({1'b0, i_pixel_row} - w_hq)
                                              : i_pixel_row;
    end

    // divider pipeline: index 0 is the input register, each later index
    // retires one quotient bit; dividend shifts out the top as quotient
    // shifts in the bottom
    logic [DS:0]     r_dv_v;
    logic [DS:0]     r_dv_lf;
    logic [50:0]     r_tq [DS+1];
    logic [12:0]     r_tr [DS+1];
    logic [50:0]     r_pq [DS+1];
    logic [20:0]     r_pr [DS+1];

    // fold and CORDIC pipeline: index 0 is the fold register
    logic [NC:0]             r_c_v;
    logic [NC:0]             r_c_lf;
    logic [NC:0]             r_c_ngt;
    logic [NC:0]             r_c_ngp;
    logic signed [31:0]      r_cxt [NC+1];
    logic signed [31:0]      r_cyt [NC+1];
    logic signed [32:0]      r_czt [NC+1];
    logic signed [31:0]      r_cxp [NC+1];
    logic signed [31:0]      r_cyp [NC+1];
    logic signed [32:0]      r_czp [NC+1];

    // multiply, round and output stages
    logic                    r_m_v;
    logic signed [55:0]      r_m_ox;
    logic signed [55:0]      r_m_oz;
    logic signed [63:0]      r_m_dx;
    logic signed [63:0]      r_m_dz;
    logic signed [31:0]      r_m_sp;
    logic                    r_r_v;
    logic signed [24:0]      r_r_ox;
    logic signed [24:0]      r_r_oz;
    logic signed [17:0]      r_r_dx;
    logic signed [17:0]      r_r_dz;
    logic signed [15:0]      r_r_dy;
    logic                    r_o_v;

    // valid chain: cleared by reset, advances every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_dv_v <= '0;
            r_c_v  <= '0;
            r_m_v  <= 1'b0;
            r_r_v  <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            r_run  <= 1'b1;
            r_dv_v <= {r_dv_v[DS-1:0], w_acc};
            r_c_v  <= {r_c_v[NC-1:0], r_dv_v[DS]};
            r_m_v  <= r_c_v[NC];
            r_r_v  <= r_m_v;
            r_o_v  <= r_r_v;
        end
    end

    // divider payload
    always_ff @(posedge i_clk) begin
        logic [13:0] t_t;
        logic [21:0] t_p;
        r_tq[0]    <= {7'd0, i_pixel_col, 24'd0};
        r_tr[0]    <= '0;
        r_pq[0]    <= {w_rowp, 31'd0};
        r_pr[0]    <= '0;
        r_dv_lf[0] <= w_left;
        for (int k = 1; k <= DS; k++) begin
            t_t = {r_tr[k-1], r_tq[k-1][50]};
            t_p = {r_pr[k-1], r_pq[k-1][50]};
            if (t_t >= {1'b0, w_width}) begin
                r_tr[k] <= 13'(t_t - {1'b0, w_width});
                r_tq[k] <= {r_tq[k-1][49:0], 1'b1};
            end else begin
                r_tr[k] <= t_t[12:0];
                r_tq[k] <= {r_tq[k-1][49:0], 1'b0};
            end
            if (t_p >= {1'b0, w_hq}) begin
                r_pr[k] <= 21'(t_p - {1'b0, w_hq});
                r_pq[k] <= {r_pq[k-1][49:0], 1'b1};
            end else begin
                r_pr[k] <= t_p[20:0];
                r_pq[k] <= {r_pq[k-1][49:0], 1'b0};
            end
            r_dv_lf[k] <= r_dv_lf[k-1];
        end
    end

    // angle turns and quadrant fold
    logic [31:0] w_th;
    logic [31:0] w_ph;
    logic [31:0] w_thf;
    logic [31:0] w_phf;
    logic        w_ngt;
    logic        w_ngp;
    always_comb begin
        w_th  = r_tq[DS][31:0] - 32'h8000_0000;
        w_ph  = 32'h4000_0000 - r_pq[DS][31:0];
        w_ngt = (w_th[31:30] == 2'b01) || (w_th[31:30] == 2'b10);
        w_ngp = (w_ph[31:30] == 2'b01) || (w_ph[31:30] == 2'b10);
        w_thf = w_ngt ? (w_th + 32'h8000_0000) : w_th;
        w_phf = w_ngp ? (w_ph + 32'h8000_0000) : w_ph;
    end

    // CORDIC payload: one rotation step per stage for both angles
    always_ff @(posedge i_clk) begin
        logic signed [32:0] at;
        r_cxt[0]   <= CORDIC_GAIN;
        r_cyt[0]   <= '0;
        r_czt[0]   <= $signed({w_thf[31], w_thf});
        r_cxp[0]   <= CORDIC_GAIN;
        r_cyp[0]   <= '0;
        r_czp[0]   <= $signed({w_phf[31], w_phf});
        r_c_ngt[0] <= w_ngt;
        r_c_ngp[0] <= w_ngp;
        r_c_lf[0]  <= r_dv_lf[DS];
        for (int i = 0; i < NC; i++) begin
            at = $signed({1'b0, atan_turn(i)});
            if (!r_czt[i][32]) begin
                r_cxt[i+1] <= r_cxt[i] - (r_cyt[i] >>> i);
                r_cyt[i+1] <= r_cyt[i] + (r_cxt[i] >>> i);
                r_czt[i+1] <= r_czt[i] - at;
            end else begin
                r_cxt[i+1] <= r_cxt[i] + (r_cyt[i] >>> i);
                r_cyt[i+1] <= r_cyt[i] - (r_cxt[i] >>> i);
                r_czt[i+1] <= r_czt[i] + at;
            end
            if (!r_czp[i][32]) begin
                r_cxp[i+1] <= r_cxp[i] - (r_cyp[i] >>> i);
                r_cyp[i+1] <= r_cyp[i] + (r_cxp[i] >>> i);
                r_czp[i+1] <= r_czp[i] - at;
            end else begin
                r_cxp[i+1] <= r_cxp[i] + (r_cyp[i] >>> i);
                r_cyp[i+1] <= r_cyp[i] - (r_cxp[i] >>> i);
                r_czp[i+1] <= r_czp[i] + at;
            end
            r_c_ngt[i+1] <= r_c_ngt[i];
            r_c_ngp[i+1] <= r_c_ngp[i];
            r_c_lf[i+1]  <= r_c_lf[i];
        end
    end

    // undo the fold, sign the half separation by eye, multiply
    logic signed [31:0] w_ct;
    logic signed [31:0] w_st;
    logic signed [31:0] w_cp;
    logic signed [31:0] w_sp;
    logic signed [23:0] w_half;
    always_comb begin
        w_ct   = r_c_ngt[NC] ? -r_cxt[NC] : r_cxt[NC];
        w_st   = r_c_ngt[NC] ? -r_cyt[NC] : r_cyt[NC];
        w_cp   = r_c_ngp[NC] ? -r_cxp[NC] : r_cxp[NC];
        w_sp   = r_c_ngp[NC] ? -r_cyp[NC] : r_cyp[NC];
        w_half = r_c_lf[NC] ? -$signed({1'b0, r_eye_separation})
                            :  $signed({1'b0, r_eye_separation});
    end

    always_ff @(posedge i_clk) begin
        r_m_ox <= w_ct * w_half;
        r_m_oz <= w_st * w_half;
        r_m_dx <= w_st * w_cp;
        r_m_dz <= w_ct * w_cp;
        r_m_sp <= w_sp;
    end

    // round half up
    always_ff @(posedge i_clk) begin
        logic signed [55:0] s_ox;
        logic signed [55:0] s_oz;
        logic signed [63:0] s_dx;
        logic signed [63:0] s_dz;
        logic signed [31:0] s_dy;
        s_ox = r_m_ox + 56'sd1073741824;
        s_oz = r_m_oz + 56'sd1073741824;
        s_dx = r_m_dx + 64'sh0000_2000_0000_0000;
        s_dz = r_m_dz + 64'sh0000_2000_0000_0000;
        s_dy = r_m_sp + 32'sd32768;
        r_r_ox <= s_ox[55:31];
        r_r_oz <= s_oz[55:31];
        r_r_dx <= s_dx[63:46];
        r_r_dz <= s_dz[63:46];
        r_r_dy <= s_dy[31:16];
    end

    // add camera position, saturate, clamp the direction
    function automatic logic signed [15:0] clamp_dir(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd16384)       r = 16'sd16384;
        else if (v < -18'sd16384) r = -16'sd16384;
        else                      r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647)       r = 32'sh7FFF_FFFF;
        else if (v < -33'sd2147483648) r = 32'sh8000_0000;
        else                           r = v[31:0];
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        logic signed [32:0] s_x;
        logic signed [32:0] s_z;
        s_x = $signed({r_pos_x[31], r_pos_x}) + $signed({{8{r_r_ox[24]}}, r_r_ox});
        s_z = $signed({r_pos_z[31], r_pos_z}) + $signed({{8{r_r_oz[24]}}, r_r_oz});
        o_origin_x <= sat32(s_x);
        o_origin_y <= r_pos_y;
        o_origin_z <= sat32(s_z);
        o_dir_x    <= clamp_dir(r_r_dx);
        o_dir_y    <= clamp_dir({{2{r_r_dy[15]}}, r_r_dy});
        o_dir_z    <= clamp_dir(r_r_dz);
    end

    assign o_valid = r_o_v;

    // every result strobe matches an accepted request, and every accepted request gets a strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(w_acc, LATENCY))
        else $error("result strobe does not match request latency");

    // folded angles lie within a quarter turn of zero
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_v[0] |-> (r_czt[0] >= -33'sd1073741824 && r_czt[0] <= 33'sd1073741823 &&
                      r_czp[0] >= -33'sd1073741824 && r_czp[0] <= 33'sd1073741823))
        else $error("CORDIC angle outside folded range");

    // direction components stay within unit range
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dir_x <= 16'sd16384 && o_dir_x >= -16'sd16384 &&
                     o_dir_y <= 16'sd16384 && o_dir_y >= -16'sd16384 &&
                     o_dir_z <= 16'sd16384 && o_dir_z >= -16'sd16384))
        else $error("direction component out of range");

endmodule
